FILE: hdl/vfc_pkg.sv
// Shared codes and widths for the voxel face culler.
package vfc_pkg;

  localparam int unsigned TYPE_W = 4;
  localparam int unsigned MASK_W = 16;
  localparam int unsigned NUM_FACES = 6;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_FACES = 2'd2;

  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_FACE = 1'b1;

  localparam logic [2:0] FACE_FRONT  = 3'd0;
  localparam logic [2:0] FACE_BACK   = 3'd1;
  localparam logic [2:0] FACE_LEFT   = 3'd2;
  localparam logic [2:0] FACE_RIGHT  = 3'd3;
  localparam logic [2:0] FACE_TOP    = 3'd4;
  localparam logic [2:0] FACE_BOTTOM = 3'd5;
  localparam logic [2:0] FACE_NONE   = 3'd6;

  localparam logic [TYPE_W-1:0] TYPE_AIR = '0;

endpackage

FILE: hdl/vfc_store.sv
// Block type store with a zeroing sweep after reset and a registered read port.
module vfc_store #(
  parameter int unsigned DEPTH = 65536,
  parameter int unsigned AW    = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      we_i,
  input  logic [AW-1:0]             addr_i,
  input  logic [vfc_pkg::TYPE_W-1:0] wdata_i,
  output logic [vfc_pkg::TYPE_W-1:0] rdata_o,
  output logic                      ready_o
);

  logic [vfc_pkg::TYPE_W-1:0] mem_q [DEPTH];
  logic [vfc_pkg::TYPE_W-1:0] rdata_q;
  logic [AW-1:0]              clr_addr_q, clr_addr_d;
  logic                       clearing_q, clearing_d;
  logic                       mem_we;
  logic [AW-1:0]              mem_addr;
  logic [vfc_pkg::TYPE_W-1:0] mem_wdata;

  always_comb begin
    clr_addr_d = clr_addr_q;
    clearing_d = clearing_q;
    if (clearing_q) begin
      clr_addr_d = clr_addr_q + AW'(1);
      if (clr_addr_q == AW'(DEPTH - 1)) begin
        clearing_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      clearing_q <= 1'b1;
    end else begin
      clr_addr_q <= clr_addr_d;
      clearing_q <= clearing_d;
    end
  end

  assign mem_we    = clearing_q | we_i;
  assign mem_addr  = clearing_q ? clr_addr_q : addr_i;
  assign mem_wdata = clearing_q ? vfc_pkg::TYPE_AIR : wdata_i;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= mem_wdata;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;
  assign ready_o = ~clearing_q;

endmodule

FILE: hdl/voxel_face_culler.sv
// Voxel chunk store with per-position visible face listing.
//
//  channel   direction  handshake                  payload
//  command   in         start_i high, busy_o low   command_i, pos_x_i, pos_y_i, pos_z_i,
//                                                   block_type_i
//  result    out        res_valid_o, one cycle     kind_o, out_x_o, out_y_o, out_z_o,
//                                                   face_dir_o, stored_type_o, last_o
//  config    in/out     APB, pready always high    transparent_mask at address 0
//
//  The store has one port, so the block and its six neighbors are read one a cycle
//  through a single address adder.
//  After reset the store is swept to air, with busy_o high until the sweep is done.
//  Each result transfer lasts one cycle; the receiver cannot stall it.
module voxel_face_culler #(
  parameter int unsigned SIDE   = 16,
  parameter int unsigned LAYERS = 256,
  parameter int unsigned TYPES  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  command_i,
  input  logic [3:0]  pos_x_i,
  input  logic [7:0]  pos_y_i,
  input  logic [3:0]  pos_z_i,
  input  logic [3:0]  block_type_i,
  output logic        res_valid_o,
  output logic        kind_o,
  output logic [3:0]  out_x_o,
  output logic [7:0]  out_y_o,
  output logic [3:0]  out_z_o,
  output logic [2:0]  face_dir_o,
  output logic [3:0]  stored_type_o,
  output logic        last_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned CELLS = SIDE * SIDE * LAYERS;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam logic [AW-1:0] OFF_X = AW'(1);
  localparam logic [AW-1:0] OFF_Z = AW'(SIDE);
  localparam logic [AW-1:0] OFF_Y = AW'(SIDE * SIDE);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_ADDR1  = 3'd2;
  localparam logic [2:0] S_ADDR2  = 3'd3;
  localparam logic [2:0] S_ACCESS = 3'd4;
  localparam logic [2:0] S_CHECK  = 3'd5;
  localparam logic [2:0] S_NBR    = 3'd6;
  localparam logic [2:0] S_EMIT   = 3'd7;

  logic [2:0]  state_q, state_d;
  logic [1:0]  cmd_q, cmd_d;
  logic [3:0]  x_q, x_d;
  logic [7:0]  y_q, y_d;
  logic [3:0]  z_q, z_d;
  logic [3:0]  blk_q, blk_d;
  logic        in_q, in_d;
  logic [AW-1:0] row_q, row_d;
  logic [AW-1:0] base_q, base_d;
  logic [2:0]  f_q, f_d;
  logic        nb_in_q, nb_in_d;
  logic [vfc_pkg::NUM_FACES-1:0] vis_q, vis_d;
  logic [3:0]  self_q, self_d;
  logic [vfc_pkg::MASK_W-1:0] mask_q, mask_d;

  logic        res_valid_q, res_valid_d;
  logic        kind_q, kind_d;
  logic [2:0]  dir_q, dir_d;
  logic [3:0]  type_q, type_d;
  logic        last_q, last_d;

  logic          st_we;
  logic [AW-1:0] st_addr;
  logic [3:0]    st_rdata;
  logic          st_ready;

  logic [AW-1:0] off;
  logic          off_sub;
  logic          nb_in;
  logic          nb_vis;
  logic [3:0]    cell_type;
  logic [vfc_pkg::NUM_FACES-1:0] eval_vis;
  logic [vfc_pkg::NUM_FACES-1:0] emit_rest;
  logic [2:0]    emit_dir;
  logic          cfg_wr;

  vfc_store #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (st_we),
    .addr_i  (st_addr),
    .wdata_i (blk_q),
    .rdata_o (st_rdata),
    .ready_o (st_ready)
  );

  // neighbor offset and bounds per face
  always_comb begin
    off     = '0;
    off_sub = 1'b0;
    nb_in   = 1'b0;
    case (f_q)
      vfc_pkg::FACE_FRONT: begin
        off   = OFF_Z;
        nb_in = ({28'd0, z_q} + 32'd1) < 32'(SIDE);
      end
      vfc_pkg::FACE_BACK: begin
        off     = OFF_Z;
        off_sub = 1'b1;
        nb_in   = z_q != 4'd0;
      end
      vfc_pkg::FACE_LEFT: begin
        off     = OFF_X;
        off_sub = 1'b1;
        nb_in   = x_q != 4'd0;
      end
      vfc_pkg::FACE_RIGHT: begin
        off   = OFF_X;
        nb_in = ({28'd0, x_q} + 32'd1) < 32'(SIDE);
      end
      vfc_pkg::FACE_TOP: begin
        off   = OFF_Y;
        nb_in = ({24'd0, y_q} + 32'd1) < 32'(LAYERS);
      end
      vfc_pkg::FACE_BOTTOM: begin
        off     = OFF_Y;
        off_sub = 1'b1;
        nb_in   = y_q != 8'd0;
      end
      default: begin
        off     = '0;
        off_sub = 1'b0;
        nb_in   = 1'b0;
      end
    endcase
  end

  // shared address adder
  always_comb begin
    st_addr = base_q;
    if (state_q == S_NBR) begin
      st_addr = off_sub ? (base_q - off) : (base_q + off);
    end
  end

  assign cell_type = in_q ? st_rdata : vfc_pkg::TYPE_AIR;
  assign nb_vis    = ~nb_in_q | (st_rdata == vfc_pkg::TYPE_AIR) | mask_q[st_rdata];

  always_comb begin
    eval_vis = vis_q;
    if (f_q != 3'd0) begin
      eval_vis[f_q - 3'd1] = nb_vis;
    end
  end

  always_comb begin
    emit_dir = vfc_pkg::FACE_NONE;
    for (int i = vfc_pkg::NUM_FACES - 1; i >= 0; i--) begin
      if (vis_q[i]) begin
        emit_dir = 3'(i);
      end
    end
    emit_rest = vis_q;
    if (emit_dir != vfc_pkg::FACE_NONE) begin
      emit_rest[emit_dir] = 1'b0;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    x_d         = x_q;
    y_d         = y_q;
    z_d         = z_q;
    blk_d       = blk_q;
    in_d        = in_q;
    row_d       = row_q;
    base_d      = base_q;
    f_d         = f_q;
    nb_in_d     = nb_in_q;
    vis_d       = vis_q;
    self_d      = self_q;
    res_valid_d = 1'b0;
    kind_d      = kind_q;
    dir_d       = dir_q;
    type_d      = type_q;
    last_d      = last_q;
    st_we       = 1'b0;

    case (state_q)
      S_CLEAR: begin
        if (st_ready) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_d   = command_i;
          x_d     = pos_x_i;
          y_d     = pos_y_i;
          z_d     = pos_z_i;
          blk_d   = block_type_i;
          state_d = S_ADDR1;
        end
      end
      S_ADDR1: begin
        in_d    = (32'(x_q) < 32'(SIDE)) && (32'(y_q) < 32'(LAYERS)) &&
                  (32'(z_q) < 32'(SIDE));
        row_d   = AW'(32'(y_q) * 32'(SIDE) + 32'(z_q));
        state_d = S_ADDR2;
      end
      S_ADDR2: begin
        base_d  = AW'(32'(row_q) * 32'(SIDE) + 32'(x_q));
        state_d = S_ACCESS;
      end
      S_ACCESS: begin
        case (cmd_q)
          vfc_pkg::CMD_WRITE: begin
            st_we   = in_q && (32'(blk_q) < 32'(TYPES));
            state_d = S_IDLE;
          end
          vfc_pkg::CMD_READ, vfc_pkg::CMD_FACES: begin
            state_d = S_CHECK;
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_CHECK: begin
        if (cmd_q == vfc_pkg::CMD_READ) begin
          res_valid_d = 1'b1;
          kind_d      = vfc_pkg::KIND_READ;
          dir_d       = vfc_pkg::FACE_FRONT;
          type_d      = cell_type;
          last_d      = 1'b1;
          state_d     = S_IDLE;
        end else if (cell_type != vfc_pkg::TYPE_AIR) begin
          self_d  = cell_type;
          f_d     = '0;
          vis_d   = '0;
          state_d = S_NBR;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_NBR: begin
        vis_d   = eval_vis;
        nb_in_d = nb_in;
        f_d     = f_q + 3'd1;
        if (f_q == 3'(vfc_pkg::NUM_FACES)) begin
          state_d = (eval_vis != '0) ? S_EMIT : S_IDLE;
        end
      end
      S_EMIT: begin
        res_valid_d = 1'b1;
        kind_d      = vfc_pkg::KIND_FACE;
        dir_d       = emit_dir;
        type_d      = self_q;
        last_d      = emit_rest == '0;
        vis_d       = emit_rest;
        if (emit_rest == '0) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    mask_d = mask_q;
    if (cfg_wr && (paddr[2] == 1'b0)) begin
      mask_d = pwdata[vfc_pkg::MASK_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      res_valid_q <= 1'b0;
      mask_q      <= '0;
      f_q         <= '0;
      vis_q       <= '0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      mask_q      <= mask_d;
      f_q         <= f_d;
      vis_q       <= vis_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    x_q     <= x_d;
    y_q     <= y_d;
    z_q     <= z_d;
    blk_q   <= blk_d;
    in_q    <= in_d;
    row_q   <= row_d;
    base_q  <= base_d;
    nb_in_q <= nb_in_d;
    self_q  <= self_d;
    kind_q  <= kind_d;
    dir_q   <= dir_d;
    type_q  <= type_d;
    last_q  <= last_d;
  end

  assign busy_o        = state_q != S_IDLE;
  assign res_valid_o   = res_valid_q;
  assign kind_o        = kind_q;
  assign out_x_o       = x_q;
  assign out_y_o       = y_q;
  assign out_z_o       = z_q;
  assign face_dir_o    = dir_q;
  assign stored_type_o = type_q;
  assign last_o        = last_q;

  assign prdata = (paddr[2] == 1'b0) ? {16'd0, mask_q} : 32'd0;
  assign pready = 1'b1;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("accepted command did not raise busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && last_o |=> !res_valid_o)
    else $error("result strobe after last");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (kind_o == vfc_pkg::KIND_READ) |-> last_o)
    else $error("read answer without last");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !st_ready |-> !res_valid_o && busy_o)
    else $error("activity during store sweep");
`endif

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for voxel_face_culler: shadow chunk store predicts reads and faces.
module testbench;

  typedef struct packed {
    logic [1:0] command;
    logic [3:0] x;
    logic [7:0] y;
    logic [3:0] z;
    logic [3:0] btype;
  } voxel_cmd_t;

  typedef struct packed {
    logic       kind;
    logic [3:0] x;
    logic [7:0] y;
    logic [3:0] z;
    logic [2:0] face;
    logic [3:0] stype;
    logic       last;
  } face_record_t;

  localparam logic [1:0] CMD_NOP      = 2'd3;
  localparam logic [2:0] MASK_ADDR    = 3'd0;
  localparam int         CHUNK_SIDE   = 16;
  localparam int         CHUNK_LAYERS = 256;
  localparam int         PHASE_ITEMS  = 45;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        start_i      = 1'b0;
  logic        busy_o;
  logic [1:0]  command_i    = '0;
  logic [3:0]  pos_x_i      = '0;
  logic [7:0]  pos_y_i      = '0;
  logic [3:0]  pos_z_i      = '0;
  logic [3:0]  block_type_i = '0;
  logic        res_valid_o;
  logic        kind_o;
  logic [3:0]  out_x_o;
  logic [7:0]  out_y_o;
  logic [3:0]  out_z_o;
  logic [2:0]  face_dir_o;
  logic [3:0]  stored_type_o;
  logic        last_o;
  logic        psel         = 1'b0;
  logic        penable      = 1'b0;
  logic        pwrite       = 1'b0;
  logic [2:0]  paddr        = '0;
  logic [31:0] pwdata       = '0;
  logic [31:0] prdata;
  logic        pready;

  voxel_face_culler u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .command_i     (command_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .pos_z_i       (pos_z_i),
    .block_type_i  (block_type_i),
    .res_valid_o   (res_valid_o),
    .kind_o        (kind_o),
    .out_x_o       (out_x_o),
    .out_y_o       (out_y_o),
    .out_z_o       (out_z_o),
    .face_dir_o    (face_dir_o),
    .stored_type_o (stored_type_o),
    .last_o        (last_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  logic [3:0]   chunk_cells [0:65535];
  logic [15:0]  transparent_bits = '0;
  voxel_cmd_t   pending_cmds[$];
  face_record_t owed_records[$];
  voxel_cmd_t   next_cmd;
  int           queued_cnt   = 0;
  int           accepted_cnt = 0;
  int           mismatch_cnt = 0;
  int           phase_cnt    = 0;
  int           idle_left    = 0;
  logic         cmd_taken    = 1'b0;
  logic         gaps_on      = 1'b1;
  logic         quiet        = 1'b0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic logic [3:0] cell_at(input int x, input int y, input int z);
    if (x < 0 || x >= CHUNK_SIDE || y < 0 || y >= CHUNK_LAYERS || z < 0 || z >= CHUNK_SIDE)
      return vfc_pkg::TYPE_AIR;
    return chunk_cells[(y * CHUNK_SIDE + z) * CHUNK_SIDE + x];
  endfunction

  function automatic logic see_through(input logic [3:0] t);
    return (t == vfc_pkg::TYPE_AIR) || transparent_bits[t];
  endfunction

  function automatic void step_pos(input int x, input int y, input int z, input logic [2:0] dir,
                                   output int nx, output int ny, output int nz);
    nx = x;
    ny = y;
    nz = z;
    case (dir)
      vfc_pkg::FACE_FRONT:  nz = z + 1;
      vfc_pkg::FACE_BACK:   nz = z - 1;
      vfc_pkg::FACE_LEFT:   nx = x - 1;
      vfc_pkg::FACE_RIGHT:  nx = x + 1;
      vfc_pkg::FACE_TOP:    ny = y + 1;
      vfc_pkg::FACE_BOTTOM: ny = y - 1;
      default: ;
    endcase
  endfunction

  function automatic string fmt_record(input face_record_t r);
    return $sformatf("kind=%0d pos=(%0d,%0d,%0d) face=%0d type=%0d last=%0d",
                     r.kind, r.x, r.y, r.z, r.face, r.stype, r.last);
  endfunction

  task automatic note_mismatch(input string msg);
    if (mismatch_cnt < 10) $display("mismatch: %s", msg);
    mismatch_cnt++;
  endtask

  task automatic predict_command(input voxel_cmd_t c);
    int           x = c.x;
    int           y = c.y;
    int           z = c.z;
    int           nx, ny, nz;
    logic [3:0]   self_t;
    logic [2:0]   dirs[$];
    face_record_t rec;
    case (c.command)
      vfc_pkg::CMD_WRITE: chunk_cells[(y * CHUNK_SIDE + z) * CHUNK_SIDE + x] = c.btype;
      vfc_pkg::CMD_READ: begin
        rec = {vfc_pkg::KIND_READ, c.x, c.y, c.z, vfc_pkg::FACE_FRONT, cell_at(x, y, z), 1'b1};
        owed_records = {owed_records, rec};
      end
      vfc_pkg::CMD_FACES: begin
        self_t = cell_at(x, y, z);
        if (self_t != vfc_pkg::TYPE_AIR) begin
          for (int d = 0; d < vfc_pkg::NUM_FACES; d++) begin
            step_pos(x, y, z, 3'(d), nx, ny, nz);
            if (see_through(cell_at(nx, ny, nz))) dirs = {dirs, 3'(d)};
          end
          for (int i = 0; i < dirs.size(); i++) begin
            rec = {vfc_pkg::KIND_FACE, c.x, c.y, c.z, dirs[i], self_t,
                   1'(i == dirs.size() - 1)};
            owed_records = {owed_records, rec};
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(negedge clk_i) begin
    if (!(start_i && !cmd_taken)) begin
      if (idle_left > 0) begin
        idle_left <= idle_left - 1;
        start_i <= 1'b0;
      end else if (pending_cmds.size() > 0 && gaps_on && !quiet && $urandom_range(0, 5) == 0) begin
        idle_left <= $urandom_range(0, 6);
        start_i <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        next_cmd = pending_cmds.pop_front();
        command_i <= next_cmd.command;
        pos_x_i <= next_cmd.x;
        pos_y_i <= next_cmd.y;
        pos_z_i <= next_cmd.z;
        block_type_i <= next_cmd.btype;
        start_i <= 1'b1;
      end else begin
        start_i <= 1'b0;
      end
      if ($urandom_range(0, 19) == 0) quiet <= !quiet;
    end
  end

  always @(posedge clk_i) begin
    face_record_t seen;
    face_record_t want;
    cmd_taken <= rst_ni && start_i && !busy_o;
    if (rst_ni && res_valid_o) begin
      seen = {kind_o, out_x_o, out_y_o, out_z_o, face_dir_o, stored_type_o, last_o};
      if (owed_records.size() == 0) begin
        note_mismatch({"unexpected transfer ", fmt_record(seen)});
      end else begin
        want = owed_records.pop_front();
        if (seen !== want)
          note_mismatch({"expected ", fmt_record(want), " got ", fmt_record(seen)});
      end
    end
    if (rst_ni && start_i && !busy_o) begin
      predict_command({command_i, pos_x_i, pos_y_i, pos_z_i, block_type_i});
      accepted_cnt++;
    end
  end

  task automatic push_cmd(input logic [1:0] cmd, input int x, input int y, input int z,
                          input int t);
    voxel_cmd_t c;
    c = {cmd, 4'(x), 8'(y), 4'(z), 4'(t)};
    pending_cmds = {pending_cmds, c};
    queued_cnt++;
    if (cmd != CMD_NOP) phase_cnt++;
  endtask

  task automatic set_mask(input logic [15:0] value);
    repeat (2) @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= MASK_ADDR;
    pwdata <= {16'h0000, value};
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    transparent_bits = value;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[15:0] !== value)
      note_mismatch($sformatf("mask readback expected %h got %h", value, prdata[15:0]));
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic drain();
    int spins = 0;
    while (accepted_cnt != queued_cnt) @(posedge clk_i);
    while (owed_records.size() > 0 && spins < 5000) begin
      @(posedge clk_i);
      spins++;
    end
    repeat (24) @(posedge clk_i);
  endtask

  function automatic int edge_pick(input int top);
    case ($urandom_range(0, 3))
      0: return 0;
      1: return top;
      default: return $urandom_range(0, top);
    endcase
  endfunction

  task automatic add_cluster();
    int cx = edge_pick(CHUNK_SIDE - 1);
    int cy = edge_pick(CHUNK_LAYERS - 1);
    int cz = edge_pick(CHUNK_SIDE - 1);
    int nx, ny, nz;
    for (int d = 0; d < vfc_pkg::NUM_FACES; d++) begin
      step_pos(cx, cy, cz, 3'(d), nx, ny, nz);
      if (nx >= 0 && nx < CHUNK_SIDE && ny >= 0 && ny < CHUNK_LAYERS && nz >= 0 &&
          nz < CHUNK_SIDE && $urandom_range(0, 2) != 0)
        push_cmd(vfc_pkg::CMD_WRITE, nx, ny, nz,
                 ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15));
    end
    push_cmd(vfc_pkg::CMD_WRITE, cx, cy, cz,
             ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 15));
    push_cmd(vfc_pkg::CMD_FACES, cx, cy, cz, $urandom_range(0, 15));
    if ($urandom_range(0, 1) == 0) begin
      step_pos(cx, cy, cz, 3'($urandom_range(0, 5)), nx, ny, nz);
      push_cmd(vfc_pkg::CMD_READ, nx, ny, nz, $urandom_range(0, 15));
    end
  endtask

  task automatic run_phase();
    phase_cnt = 0;
    while (phase_cnt < PHASE_ITEMS) begin
      if ($urandom_range(0, 4) == 0)
        push_cmd(2'($urandom_range(0, 3)), $urandom_range(0, 15), $urandom_range(0, 255),
                 $urandom_range(0, 15), $urandom_range(0, 15));
      else
        add_cluster();
    end
    drain();
  endtask

  initial begin
    for (int i = 0; i < 65536; i++) chunk_cells[i] = vfc_pkg::TYPE_AIR;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    set_mask(16'h0000);

    push_cmd(vfc_pkg::CMD_READ, 0, 0, 0, 0);
    push_cmd(vfc_pkg::CMD_FACES, 0, 0, 0, 0);
    push_cmd(vfc_pkg::CMD_WRITE, 0, 0, 0, 15);
    push_cmd(vfc_pkg::CMD_FACES, 0, 0, 0, 0);
    push_cmd(vfc_pkg::CMD_WRITE, 15, 255, 15, 1);
    push_cmd(vfc_pkg::CMD_FACES, 15, 255, 15, 15);
    push_cmd(vfc_pkg::CMD_WRITE, 1, 0, 0, 2);
    push_cmd(vfc_pkg::CMD_WRITE, 0, 1, 0, 3);
    push_cmd(vfc_pkg::CMD_WRITE, 0, 0, 1, 4);
    push_cmd(vfc_pkg::CMD_FACES, 0, 0, 0, 0);
    push_cmd(vfc_pkg::CMD_WRITE, 8, 100, 8, 5);
    push_cmd(vfc_pkg::CMD_WRITE, 8, 100, 9, 6);
    push_cmd(vfc_pkg::CMD_WRITE, 8, 100, 7, 6);
    push_cmd(vfc_pkg::CMD_WRITE, 7, 100, 8, 6);
    push_cmd(vfc_pkg::CMD_WRITE, 9, 100, 8, 6);
    push_cmd(vfc_pkg::CMD_WRITE, 8, 101, 8, 6);
    push_cmd(vfc_pkg::CMD_WRITE, 8, 99, 8, 6);
    push_cmd(vfc_pkg::CMD_FACES, 8, 100, 8, 0);
    push_cmd(vfc_pkg::CMD_READ, 8, 100, 8, 15);
    push_cmd(CMD_NOP, 15, 255, 15, 15);
    push_cmd(vfc_pkg::CMD_WRITE, 0, 0, 0, 0);
    push_cmd(vfc_pkg::CMD_READ, 0, 0, 0, 0);
    push_cmd(vfc_pkg::CMD_FACES, 0, 0, 0, 0);
    drain();
    run_phase();

    set_mask(16'hFFFF);
    push_cmd(vfc_pkg::CMD_FACES, 8, 100, 8, 0);
    run_phase();

    set_mask(16'($urandom));
    push_cmd(vfc_pkg::CMD_FACES, 8, 100, 8, 0);
    run_phase();

    gaps_on = 1'b0;
    set_mask(16'hFFFE);
    push_cmd(vfc_pkg::CMD_FACES, 8, 100, 8, 0);
    run_phase();

    if (mismatch_cnt == 0 && owed_records.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
